/* rtl/dpf_pkg.sv */
// Shared types, widths and codes for the bitmap pixel fetch block.
// No dependencies; dpf_if, dpf_geom and dib_pixel_fetch_top refer to this package.
package dpf_pkg;

  localparam int unsigned IMAGE_BYTES     = 65536;
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned MAX_DIMENSION   = 4096;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned BADDR_W    = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PIDX_W     = 8;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned BPP_W      = 6;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned BASE_W     = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STRIDE_W   = 16;
  localparam int unsigned XOFF_W     = 16;
  localparam int unsigned ROWBITS_W  = DIM_W + 5;
  localparam int unsigned PROD_W     = DIM_W + STRIDE_W;
  localparam int unsigned ADDR_W     = 30;

  localparam logic [BPP_W-1:0] BPP_1  = 6'd1;
  localparam logic [BPP_W-1:0] BPP_4  = 6'd4;
  localparam logic [BPP_W-1:0] BPP_8  = 6'd8;
  localparam logic [BPP_W-1:0] BPP_16 = 6'd16;
  localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
  localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

  localparam logic [BPP_W-1:0]  RST_BPP    = 6'd8;
  localparam logic [DIM_W-1:0]  RST_WIDTH  = 13'd1;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 13'd1;
  localparam logic [BASE_W-1:0] RST_BASE   = 16'd0;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_BYTE = 2'd0,
    OP_WRITE_PAL  = 2'd1,
    OP_READ       = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_DEPTH   = 2'd2,
    ST_STORE   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPP    = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_BASE   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADDR,
    S_CHK,
    S_RD,
    S_DECODE,
    S_PAL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [BPP_W-1:0]  bpp;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [BASE_W-1:0] base;
  } cfg_t;

  typedef struct packed {
    status_e             status;
    logic [DIM_W-1:0]    row;
    logic [STRIDE_W-1:0] stride;
    logic [XOFF_W-1:0]   xoff;
    logic [2:0]          sub;
    logic [1:0]          last_byte;
    logic                palette;
  } geom_t;

endpackage

/* rtl/dpf_if.sv */
// Request and response channel interfaces for the bitmap pixel fetch block.
// Depends on dpf_pkg for field widths.
interface dpf_req_if;
  logic                              valid;
  logic                              ready;
  logic [dpf_pkg::OP_W-1:0]          operation;
  logic [dpf_pkg::BADDR_W-1:0]       byte_address;
  logic [dpf_pkg::BYTE_W-1:0]        byte_value;
  logic [dpf_pkg::PIDX_W-1:0]        palette_index;
  logic [dpf_pkg::COLOR_W-1:0]       palette_color;
  logic [dpf_pkg::COORD_W-1:0]       pixel_x;
  logic [dpf_pkg::COORD_W-1:0]       pixel_y;

  modport source (
    output valid, operation, byte_address, byte_value, palette_index, palette_color,
    output pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, operation, byte_address, byte_value, palette_index, palette_color,
    input  pixel_x, pixel_y,
    output ready
  );
endinterface

interface dpf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dpf_pkg::BYTE_W-1:0]    red;
  logic [dpf_pkg::BYTE_W-1:0]    green;
  logic [dpf_pkg::BYTE_W-1:0]    blue;
  logic [dpf_pkg::STATUS_W-1:0]  status;

  modport source (
    output valid, red, green, blue, status,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, status,
    output ready
  );
endinterface

/* rtl/dpf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dpf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dpf_geom.sv */
// Pixel geometry: depth check, bounds check, row stride, bottom-up row and byte offset.
// Depends on dpf_pkg.
module dpf_geom #(
  parameter int unsigned MaxDimension = dpf_pkg::MAX_DIMENSION
) (
  input  dpf_pkg::cfg_t                  cfg_i,
  input  logic [dpf_pkg::COORD_W-1:0]    x_i,
  input  logic [dpf_pkg::COORD_W-1:0]    y_i,
  output dpf_pkg::geom_t                 geom_o
);

  logic [dpf_pkg::DIM_W-1:0]     w_eff;
  logic [dpf_pkg::DIM_W-1:0]     h_eff;
  logic [dpf_pkg::ROWBITS_W-1:0] row_bits;
  logic [dpf_pkg::ROWBITS_W-1:0] row_words;
  logic [dpf_pkg::ROWBITS_W-1:0] w_ext;
  logic [dpf_pkg::XOFF_W-1:0]    x_ext;
  logic                          depth_ok;

  always_comb begin
    w_eff = cfg_i.width;
    h_eff = cfg_i.height;
    if (32'(cfg_i.width) > 32'(MaxDimension)) begin
      w_eff = dpf_pkg::DIM_W'(MaxDimension);
    end
    if (32'(cfg_i.height) > 32'(MaxDimension)) begin
      h_eff = dpf_pkg::DIM_W'(MaxDimension);
    end
    w_ext = dpf_pkg::ROWBITS_W'(w_eff);
    x_ext = dpf_pkg::XOFF_W'(x_i);

    depth_ok          = 1'b1;
    row_bits          = '0;
    geom_o.xoff       = '0;
    geom_o.last_byte  = 2'd0;
    geom_o.palette    = 1'b1;
    case (cfg_i.bpp)
      dpf_pkg::BPP_1: begin
        row_bits    = w_ext;
        geom_o.xoff = x_ext >> 3;
      end
      dpf_pkg::BPP_4: begin
        row_bits    = w_ext << 2;
        geom_o.xoff = x_ext >> 1;
      end
      dpf_pkg::BPP_8: begin
        row_bits    = w_ext << 3;
        geom_o.xoff = x_ext;
      end
      dpf_pkg::BPP_16: begin
        row_bits         = w_ext << 4;
        geom_o.xoff      = x_ext << 1;
        geom_o.last_byte = 2'd1;
        geom_o.palette   = 1'b0;
      end
      dpf_pkg::BPP_24: begin
        row_bits         = (w_ext << 4) + (w_ext << 3);
        geom_o.xoff      = (x_ext << 1) + x_ext;
        geom_o.last_byte = 2'd2;
        geom_o.palette   = 1'b0;
      end
      dpf_pkg::BPP_32: begin
        row_bits         = w_ext << 5;
        geom_o.xoff      = x_ext << 2;
        geom_o.last_byte = 2'd2;
        geom_o.palette   = 1'b0;
      end
      default: begin
        depth_ok = 1'b0;
      end
    endcase

    row_words     = (row_bits + dpf_pkg::ROWBITS_W'(31)) >> 5;
    geom_o.stride = dpf_pkg::STRIDE_W'(row_words) << 2;
    geom_o.row    = h_eff - dpf_pkg::DIM_W'(1) - dpf_pkg::DIM_W'(y_i);
    geom_o.sub    = x_i[2:0];

    if (!depth_ok) begin
      geom_o.status = dpf_pkg::ST_DEPTH;
    end else if ((dpf_pkg::DIM_W'(x_i) >= w_eff) || (dpf_pkg::DIM_W'(y_i) >= h_eff)) begin
      geom_o.status = dpf_pkg::ST_OUTSIDE;
    end else begin
      geom_o.status = dpf_pkg::ST_OK;
    end
  end

endmodule

/* rtl/dib_pixel_fetch_top.sv */
// Bitmap pixel fetch top: config registers, sequencer, image store and palette store.
// Reads go through S_MUL, S_ADDR, S_CHK, then S_DONE on an error, else S_RD, S_DECODE,
// S_PAL (indexed) and S_DONE; bytes come one per cycle through the single image read port.
// Byte and palette writes are taken in S_IDLE and leave the request side ready.
// Reset clears config to 8 bpp, 1 x 1, base 0 and empties the result register;
// the stores are not cleared.
module dib_pixel_fetch_top #(
  parameter int unsigned ImageBytes     = dpf_pkg::IMAGE_BYTES,
  parameter int unsigned PaletteEntries = dpf_pkg::PALETTE_ENTRIES,
  parameter int unsigned MaxDimension   = dpf_pkg::MAX_DIMENSION
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dpf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  dpf_req_if.sink                          req,
  dpf_rsp_if.source                        rsp
);

  localparam int unsigned ImgAw = (ImageBytes > 1) ? $clog2(ImageBytes) : 1;
  localparam int unsigned PalAw = (PaletteEntries > 1) ? $clog2(PaletteEntries) : 1;

  dpf_pkg::state_e state_q, state_d;
  dpf_pkg::cfg_t   cfg_q;
  dpf_pkg::geom_t  geom, geom_q;
  dpf_pkg::status_e st_q;

  logic [dpf_pkg::PROD_W-1:0]  prod;
  logic [dpf_pkg::ADDR_W-1:0]  prod_q;
  logic [dpf_pkg::ADDR_W-1:0]  addr_q;
  logic [1:0]                  cnt_q;
  logic [1:0]                  rd_ofs;
  logic [dpf_pkg::BYTE_W-1:0]  bytes_q [3];
  logic [dpf_pkg::COLOR_W-1:0] rgb_q;
  logic [dpf_pkg::COLOR_W-1:0] direct_rgb;
  logic [dpf_pkg::PIDX_W-1:0]  pal_idx;
  logic                        idx_ok;
  logic                        over;

  logic                        out_valid_q;
  logic [dpf_pkg::COLOR_W-1:0] out_rgb_q;
  logic [dpf_pkg::STATUS_W-1:0] out_status_q;
  logic                        out_free;
  logic                        in_fire;
  logic                        rsp_fire;

  logic                        img_we;
  logic [ImgAw-1:0]            img_raddr;
  logic [dpf_pkg::BYTE_W-1:0]  img_rdata;
  logic                        pal_we;
  logic [dpf_pkg::COLOR_W-1:0] pal_rdata;

  assign req.ready = (state_q == dpf_pkg::S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign rsp_fire  = rsp.valid && rsp.ready;
  assign out_free  = !out_valid_q || rsp.ready;

  assign rsp.valid  = out_valid_q;
  assign rsp.red    = out_rgb_q[23:16];
  assign rsp.green  = out_rgb_q[15:8];
  assign rsp.blue   = out_rgb_q[7:0];
  assign rsp.status = out_status_q;

  dpf_geom #(
    .MaxDimension(MaxDimension)
  ) u_geom (
    .cfg_i  (cfg_q),
    .x_i    (req.pixel_x),
    .y_i    (req.pixel_y),
    .geom_o (geom)
  );

  assign img_we = in_fire && (req.operation == dpf_pkg::OP_WRITE_BYTE) &&
                  (32'(req.byte_address) < 32'(ImageBytes));
  assign pal_we = in_fire && (req.operation == dpf_pkg::OP_WRITE_PAL) &&
                  (32'(req.palette_index) < 32'(PaletteEntries));

  assign rd_ofs    = (state_q == dpf_pkg::S_RD) ? (cnt_q + 2'd1) : 2'd0;
  assign img_raddr = ImgAw'(addr_q) + ImgAw'(rd_ofs);

  dpf_ram #(
    .Width(dpf_pkg::BYTE_W),
    .Depth(ImageBytes)
  ) u_image (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (ImgAw'(req.byte_address)),
    .wdata_i (req.byte_value),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  dpf_ram #(
    .Width(dpf_pkg::COLOR_W),
    .Depth(PaletteEntries)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (PalAw'(req.palette_index)),
    .wdata_i (req.palette_color),
    .raddr_i (PalAw'(pal_idx)),
    .rdata_o (pal_rdata)
  );

  assign prod = geom_q.row * geom_q.stride;
  assign over = (32'(addr_q) + 32'(geom_q.last_byte)) >= 32'(ImageBytes);

  always_comb begin
    case (cfg_q.bpp)
      dpf_pkg::BPP_1: pal_idx = {7'd0, bytes_q[0][3'd7 - geom_q.sub]};
      dpf_pkg::BPP_4: pal_idx = geom_q.sub[0] ? {4'd0, bytes_q[0][3:0]}
                                              : {4'd0, bytes_q[0][7:4]};
      default:        pal_idx = bytes_q[0];
    endcase
    idx_ok = 32'(pal_idx) < 32'(PaletteEntries);
    if (cfg_q.bpp == dpf_pkg::BPP_16) begin
      direct_rgb = {bytes_q[1][6:2], 3'd0,
                    bytes_q[1][1:0], bytes_q[0][7:5], 3'd0,
                    bytes_q[0][4:0], 3'd0};
    end else begin
      direct_rgb = {bytes_q[2], bytes_q[1], bytes_q[0]};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dpf_pkg::S_IDLE: begin
        if (in_fire && (req.operation == dpf_pkg::OP_READ)) begin
          state_d = dpf_pkg::S_MUL;
        end
      end
      dpf_pkg::S_MUL:  state_d = dpf_pkg::S_ADDR;
      dpf_pkg::S_ADDR: state_d = dpf_pkg::S_CHK;
      dpf_pkg::S_CHK: begin
        if ((st_q != dpf_pkg::ST_OK) || over) begin
          state_d = dpf_pkg::S_DONE;
        end else begin
          state_d = dpf_pkg::S_RD;
        end
      end
      dpf_pkg::S_RD: begin
        if (cnt_q == geom_q.last_byte) begin
          state_d = dpf_pkg::S_DECODE;
        end
      end
      dpf_pkg::S_DECODE: begin
        if (geom_q.palette && idx_ok) begin
          state_d = dpf_pkg::S_PAL;
        end else begin
          state_d = dpf_pkg::S_DONE;
        end
      end
      dpf_pkg::S_PAL: state_d = dpf_pkg::S_DONE;
      dpf_pkg::S_DONE: begin
        if (out_free) begin
          state_d = dpf_pkg::S_IDLE;
        end
      end
      default: state_d = dpf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp    <= dpf_pkg::RST_BPP;
      cfg_q.width  <= dpf_pkg::RST_WIDTH;
      cfg_q.height <= dpf_pkg::RST_HEIGHT;
      cfg_q.base   <= dpf_pkg::RST_BASE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dpf_pkg::CFG_BPP:    cfg_q.bpp    <= cfg_data_i[dpf_pkg::BPP_W-1:0];
        dpf_pkg::CFG_WIDTH:  cfg_q.width  <= cfg_data_i[dpf_pkg::DIM_W-1:0];
        dpf_pkg::CFG_HEIGHT: cfg_q.height <= cfg_data_i[dpf_pkg::DIM_W-1:0];
        dpf_pkg::CFG_BASE:   cfg_q.base   <= cfg_data_i[dpf_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      dpf_pkg::S_IDLE: begin
        if (in_fire) begin
          geom_q <= geom;
          st_q   <= geom.status;
          rgb_q  <= '0;
        end
      end
      dpf_pkg::S_MUL: begin
        prod_q <= dpf_pkg::ADDR_W'(prod);
      end
      dpf_pkg::S_ADDR: begin
        addr_q <= dpf_pkg::ADDR_W'(cfg_q.base) + prod_q + dpf_pkg::ADDR_W'(geom_q.xoff);
      end
      dpf_pkg::S_CHK: begin
        cnt_q <= 2'd0;
        if ((st_q == dpf_pkg::ST_OK) && over) begin
          st_q <= dpf_pkg::ST_STORE;
        end
      end
      dpf_pkg::S_RD: begin
        bytes_q[cnt_q] <= img_rdata;
        if (cnt_q != geom_q.last_byte) begin
          cnt_q <= cnt_q + 2'd1;
        end
      end
      dpf_pkg::S_DECODE: begin
        if (!geom_q.palette) begin
          rgb_q <= direct_rgb;
        end else if (!idx_ok) begin
          st_q <= dpf_pkg::ST_STORE;
        end
      end
      dpf_pkg::S_PAL: begin
        rgb_q <= pal_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == dpf_pkg::S_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == dpf_pkg::S_DONE) && out_free) begin
      out_rgb_q    <= rgb_q;
      out_status_q <= st_q;
    end
  end

  a_err_color_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && (rsp.status != dpf_pkg::ST_OK)) |->
      ((rsp.red == 8'd0) && (rsp.green == 8'd0) && (rsp.blue == 8'd0)))
    else $error("error result carries a color");

  a_read_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (req.operation == dpf_pkg::OP_READ)) |=> (state_q == dpf_pkg::S_MUL))
    else $error("read item did not start the fetch");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpf_pkg::S_RD) |-> (cnt_q <= geom_q.last_byte))
    else $error("byte counter ran past the pixel");

  a_pal_after_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpf_pkg::S_PAL) |-> ($past(state_q) == dpf_pkg::S_DECODE))
    else $error("palette read without index decode");

endmodule

/* tb/tb.sv */
// Self-checking testbench for dib_pixel_fetch_top: random and directed pixel traffic
// with an in-bench predictor of the bitmap decode. Depends on dpf_pkg, dpf_if and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dpf_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int unsigned IDLE_PCT      = 14;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS  = 1150;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [dpf_pkg::OP_W-1:0]    operation;
    logic [dpf_pkg::BADDR_W-1:0] byte_address;
    logic [dpf_pkg::BYTE_W-1:0]  byte_value;
    logic [dpf_pkg::PIDX_W-1:0]  palette_index;
    logic [dpf_pkg::COLOR_W-1:0] palette_color;
    logic [dpf_pkg::COORD_W-1:0] pixel_x;
    logic [dpf_pkg::COORD_W-1:0] pixel_y;
  } pixel_req_t;

  typedef struct packed {
    logic [dpf_pkg::BYTE_W-1:0] red;
    logic [dpf_pkg::BYTE_W-1:0] green;
    logic [dpf_pkg::BYTE_W-1:0] blue;
    dpf_pkg::status_e           status;
  } pixel_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [dpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [dpf_pkg::CFG_DATA_W-1:0] cfg_data_i;

  dpf_req_if req_if ();
  dpf_rsp_if rsp_if ();

  dib_pixel_fetch_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  logic [dpf_pkg::BYTE_W-1:0]  image_mem       [dpf_pkg::IMAGE_BYTES];
  bit                          image_written   [dpf_pkg::IMAGE_BYTES];
  logic [dpf_pkg::COLOR_W-1:0] palette_mem     [dpf_pkg::PALETTE_ENTRIES];
  bit                          palette_written [dpf_pkg::PALETTE_ENTRIES];
  logic [dpf_pkg::BPP_W-1:0]   depth_reg;
  logic [dpf_pkg::DIM_W-1:0]   width_reg;
  logic [dpf_pkg::DIM_W-1:0]   height_reg;
  logic [dpf_pkg::BASE_W-1:0]  base_reg;

  pixel_t      pending_pixels[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned idle_pct;
  int unsigned rsp_hold_cycles;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clip_dim(logic [dpf_pkg::DIM_W-1:0] d);
    return (d > dpf_pkg::MAX_DIMENSION) ? dpf_pkg::MAX_DIMENSION : 32'(d);
  endfunction

  function automatic bit depth_ok();
    case (depth_reg)
      dpf_pkg::BPP_1, dpf_pkg::BPP_4, dpf_pkg::BPP_8,
      dpf_pkg::BPP_16, dpf_pkg::BPP_24, dpf_pkg::BPP_32: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pixel_bytes();
    case (depth_reg)
      dpf_pkg::BPP_16: return 2;
      dpf_pkg::BPP_24, dpf_pkg::BPP_32: return 3;
      default: return 1;
    endcase
  endfunction

  function automatic bit pixel_on_image(logic [dpf_pkg::COORD_W-1:0] x,
                                        logic [dpf_pkg::COORD_W-1:0] y);
    return (x < clip_dim(width_reg)) && (y < clip_dim(height_reg));
  endfunction

  function automatic longint pixel_addr(logic [dpf_pkg::COORD_W-1:0] x,
                                        logic [dpf_pkg::COORD_W-1:0] y);
    longint w, h, bpp, xx, yy, stride, row;
    w = clip_dim(width_reg);
    h = clip_dim(height_reg);
    bpp = depth_reg;
    xx = x;
    yy = y;
    stride = ((w * bpp + 31) / 32) * 4;
    row = longint'(base_reg) + (h - 1 - yy) * stride;
    case (depth_reg)
      dpf_pkg::BPP_1: return row + (xx >> 3);
      dpf_pkg::BPP_4: return row + (xx >> 1);
      default: return row + xx * (bpp >> 3);
    endcase
  endfunction

  function automatic logic [dpf_pkg::PIDX_W-1:0] palette_slot(
      logic [dpf_pkg::COORD_W-1:0] x, logic [dpf_pkg::BYTE_W-1:0] b0);
    case (depth_reg)
      dpf_pkg::BPP_1: return {7'd0, b0[3'd7 - x[2:0]]};
      dpf_pkg::BPP_4: return x[0] ? {4'd0, b0[3:0]} : {4'd0, b0[7:4]};
      default: return b0;
    endcase
  endfunction

  function automatic pixel_t predict_pixel(logic [dpf_pkg::COORD_W-1:0] x,
                                           logic [dpf_pkg::COORD_W-1:0] y);
    pixel_t                     p;
    longint                     a;
    int                         n;
    logic [dpf_pkg::BYTE_W-1:0] b0, b1, b2;
    logic [15:0]                wd;
    p = '0;
    p.status = dpf_pkg::ST_OK;
    if (!depth_ok()) begin
      p.status = dpf_pkg::ST_DEPTH;
    end else if (!pixel_on_image(x, y)) begin
      p.status = dpf_pkg::ST_OUTSIDE;
    end else begin
      a = pixel_addr(x, y);
      n = pixel_bytes();
      if (a + n > dpf_pkg::IMAGE_BYTES) begin
        p.status = dpf_pkg::ST_STORE;
      end else begin
        b0 = image_mem[dpf_pkg::BADDR_W'(a)];
        b1 = (n > 1) ? image_mem[dpf_pkg::BADDR_W'(a + 1)] : '0;
        b2 = (n > 2) ? image_mem[dpf_pkg::BADDR_W'(a + 2)] : '0;
        case (depth_reg)
          dpf_pkg::BPP_16: begin
            wd = {b1, b0};
            p.red   = {wd[14:10], 3'b000};
            p.green = {wd[9:5], 3'b000};
            p.blue  = {wd[4:0], 3'b000};
          end
          dpf_pkg::BPP_24, dpf_pkg::BPP_32: begin
            {p.red, p.green, p.blue} = {b2, b1, b0};
          end
          default: begin
            {p.red, p.green, p.blue} = palette_mem[palette_slot(x, b0)];
          end
        endcase
      end
    end
    return p;
  endfunction

  function automatic pixel_req_t noise_item();
    pixel_req_t r;
    r.operation     = OP_RESERVED;
    r.byte_address  = dpf_pkg::BADDR_W'($urandom_range(65535));
    r.byte_value    = dpf_pkg::BYTE_W'($urandom_range(255));
    r.palette_index = dpf_pkg::PIDX_W'($urandom_range(255));
    r.palette_color = dpf_pkg::COLOR_W'($urandom_range(24'hFFFFFF));
    r.pixel_x       = dpf_pkg::COORD_W'($urandom_range(4095));
    r.pixel_y       = dpf_pkg::COORD_W'($urandom_range(4095));
    return r;
  endfunction

  task automatic send_item(pixel_req_t r);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.operation     <= r.operation;
    req_if.byte_address  <= r.byte_address;
    req_if.byte_value    <= r.byte_value;
    req_if.palette_index <= r.palette_index;
    req_if.palette_color <= r.palette_color;
    req_if.pixel_x       <= r.pixel_x;
    req_if.pixel_y       <= r.pixel_y;
    do begin
      @(negedge clk_i);
      taken = (req_if.ready === 1'b1);
      @(posedge clk_i);
    end while (!taken);
    case (r.operation)
      dpf_pkg::OP_WRITE_BYTE: begin
        image_mem[r.byte_address]     = r.byte_value;
        image_written[r.byte_address] = 1'b1;
      end
      dpf_pkg::OP_WRITE_PAL: begin
        palette_mem[r.palette_index]     = r.palette_color;
        palette_written[r.palette_index] = 1'b1;
      end
      dpf_pkg::OP_READ: pending_pixels.push_back(predict_pixel(r.pixel_x, r.pixel_y));
      default: ;
    endcase
    if (r.operation != OP_RESERVED) items_sent++;
  endtask

  task automatic write_byte(logic [dpf_pkg::BADDR_W-1:0] addr,
                            logic [dpf_pkg::BYTE_W-1:0] value);
    pixel_req_t r;
    r = noise_item();
    r.operation    = dpf_pkg::OP_WRITE_BYTE;
    r.byte_address = addr;
    r.byte_value   = value;
    send_item(r);
  endtask

  task automatic write_palette(logic [dpf_pkg::PIDX_W-1:0] slot,
                               logic [dpf_pkg::COLOR_W-1:0] color);
    pixel_req_t r;
    r = noise_item();
    r.operation     = dpf_pkg::OP_WRITE_PAL;
    r.palette_index = slot;
    r.palette_color = color;
    send_item(r);
  endtask

  task automatic send_reserved();
    send_item(noise_item());
  endtask

  // fill any unwritten byte or palette entry the pixel needs, then read it
  task automatic read_pixel(logic [dpf_pkg::COORD_W-1:0] x, logic [dpf_pkg::COORD_W-1:0] y);
    pixel_req_t                 r;
    longint                     a;
    logic [dpf_pkg::PIDX_W-1:0] slot;
    if (depth_ok() && pixel_on_image(x, y)) begin
      a = pixel_addr(x, y);
      for (int k = 0; k < pixel_bytes(); k++) begin
        if (a + k < dpf_pkg::IMAGE_BYTES && !image_written[dpf_pkg::BADDR_W'(a + k)])
          write_byte(dpf_pkg::BADDR_W'(a + k), dpf_pkg::BYTE_W'($urandom_range(255)));
      end
      if (depth_reg <= dpf_pkg::BPP_8 && a < dpf_pkg::IMAGE_BYTES) begin
        slot = palette_slot(x, image_mem[dpf_pkg::BADDR_W'(a)]);
        if (!palette_written[slot])
          write_palette(slot, dpf_pkg::COLOR_W'($urandom_range(24'hFFFFFF)));
      end
    end
    r = noise_item();
    r.operation = dpf_pkg::OP_READ;
    r.pixel_x   = x;
    r.pixel_y   = y;
    send_item(r);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(dpf_pkg::cfg_reg_e idx, logic [dpf_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_image(int unsigned bpp, int unsigned w, int unsigned h,
                               int unsigned base);
    logic [dpf_pkg::CFG_DATA_W-1:0] bpp_word, w_word, h_word;
    bpp_word = (dpf_pkg::CFG_DATA_W'($urandom) & 16'hFFC0) |
               dpf_pkg::CFG_DATA_W'(bpp & 32'h3F);
    w_word   = (dpf_pkg::CFG_DATA_W'($urandom) & 16'hE000) |
               dpf_pkg::CFG_DATA_W'(w & 32'h1FFF);
    h_word   = (dpf_pkg::CFG_DATA_W'($urandom) & 16'hE000) |
               dpf_pkg::CFG_DATA_W'(h & 32'h1FFF);
    settle();
    write_reg(dpf_pkg::CFG_BPP, bpp_word);
    write_reg(dpf_pkg::CFG_WIDTH, w_word);
    write_reg(dpf_pkg::CFG_HEIGHT, h_word);
    write_reg(dpf_pkg::CFG_BASE, dpf_pkg::CFG_DATA_W'(base));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    depth_reg  = bpp_word[dpf_pkg::BPP_W-1:0];
    width_reg  = w_word[dpf_pkg::DIM_W-1:0];
    height_reg = h_word[dpf_pkg::DIM_W-1:0];
    base_reg   = dpf_pkg::BASE_W'(base);
  endtask

  task automatic test_reset_defaults();
    write_palette(8'd0, 24'h000000);
    write_palette(8'd255, 24'hFFFFFF);
    write_byte(16'h0000, 8'hFF);
    write_byte(16'hFFFF, 8'h00);
    read_pixel(0, 0);
    read_pixel(1, 0);
    read_pixel(0, 1);
    read_pixel(4095, 4095);
    send_reserved();
    write_byte(16'h0000, 8'h00);
    read_pixel(0, 0);
  endtask

  task automatic test_indexed_depths();
    program_image(dpf_pkg::BPP_1, 13, 3, 16'h0100);
    write_byte(16'h0108, 8'hA5);
    write_byte(16'h0109, 8'h3C);
    read_pixel(0, 0);
    read_pixel(7, 0);
    read_pixel(8, 0);
    read_pixel(12, 0);
    read_pixel(0, 2);
    program_image(dpf_pkg::BPP_4, 5, 2, 16'h0200);
    write_byte(16'h0200, 8'h9F);
    read_pixel(0, 1);
    read_pixel(1, 1);
    read_pixel(4, 1);
  endtask

  task automatic test_direct_color();
    program_image(dpf_pkg::BPP_16, 3, 2, 16'h0300);
    write_byte(16'h0308, 8'hFF);
    write_byte(16'h0309, 8'hFF);
    write_byte(16'h030A, 8'h00);
    write_byte(16'h030B, 8'h80);
    read_pixel(0, 0);
    read_pixel(1, 0);
    program_image(dpf_pkg::BPP_24, 2, 1, 16'h0400);
    read_pixel(1, 0);
    program_image(dpf_pkg::BPP_32, 2, 1, 16'h0500);
    read_pixel(1, 0);
  endtask

  task automatic test_error_status();
    program_image(0, 4, 4, 0);
    read_pixel(0, 0);
    program_image(63, 4, 4, 0);
    read_pixel(4095, 4095);
    program_image(2, 4, 4, 0);
    read_pixel(1, 1);
    program_image(dpf_pkg::BPP_8, 0, 5, 0);
    read_pixel(0, 0);
    program_image(dpf_pkg::BPP_8, 5, 0, 0);
    read_pixel(0, 0);
    program_image(dpf_pkg::BPP_32, 8191, 8191, 65535);
    read_pixel(0, 0);
    read_pixel(0, 4095);
    read_pixel(4095, 4095);
    program_image(dpf_pkg::BPP_16, 4096, 1, 65534);
    read_pixel(0, 0);
    read_pixel(1, 0);
  endtask

  task automatic test_backpressure();
    program_image(dpf_pkg::BPP_24, 6, 6, 16'h0800);
    rsp_hold_cycles = 300;
    repeat (40) read_pixel(dpf_pkg::COORD_W'($urandom_range(5)),
                           dpf_pkg::COORD_W'($urandom_range(5)));
  endtask

  task automatic test_random_traffic();
    logic [dpf_pkg::BPP_W-1:0] depths [6] = '{dpf_pkg::BPP_1, dpf_pkg::BPP_4,
                                              dpf_pkg::BPP_8, dpf_pkg::BPP_16,
                                              dpf_pkg::BPP_24, dpf_pkg::BPP_32};
    int unsigned start, phase, wx, hy, pick, bpp, w, h, base;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      idle_pct = (phase == 1) ? 0 : IDLE_PCT;
      bpp  = ($urandom_range(9) == 0) ? $urandom_range(63) :
                                        32'(depths[3'($urandom_range(5))]);
      w    = ($urandom_range(7) == 0) ? $urandom_range(8191) : $urandom_range(1, 48);
      h    = ($urandom_range(7) == 0) ? $urandom_range(8191) : $urandom_range(1, 48);
      base = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(16384);
      program_image(bpp, w, h, base);
      wx = clip_dim(width_reg);
      hy = clip_dim(height_reg);
      repeat ($urandom_range(60, 140)) begin
        pick = $urandom_range(99);
        if (pick < 62 && wx != 0 && hy != 0)
          read_pixel(dpf_pkg::COORD_W'($urandom_range(wx - 1)),
                     dpf_pkg::COORD_W'($urandom_range(hy - 1)));
        else if (pick < 74)
          read_pixel(dpf_pkg::COORD_W'($urandom_range((wx + 2 > 4095) ? 4095 : wx + 2)),
                     dpf_pkg::COORD_W'($urandom_range((hy + 2 > 4095) ? 4095 : hy + 2)));
        else if (pick < 80)
          read_pixel(dpf_pkg::COORD_W'($urandom_range(4095)),
                     dpf_pkg::COORD_W'($urandom_range(4095)));
        else if (pick < 88)
          write_byte(dpf_pkg::BADDR_W'($urandom_range(65535)),
                     dpf_pkg::BYTE_W'($urandom_range(255)));
        else if (pick < 95)
          write_palette(dpf_pkg::PIDX_W'($urandom_range(255)),
                        dpf_pkg::COLOR_W'($urandom_range(24'hFFFFFF)));
        else
          send_reserved();
      end
      phase++;
    end
    idle_pct = IDLE_PCT;
  endtask

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  initial begin : result_checker
    pixel_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result red %0h green %0h blue %0h status %0d", $time,
                   rsp_if.red, rsp_if.green, rsp_if.blue, rsp_if.status);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("red", want.red, rsp_if.red);
          check_field("green", want.green, rsp_if.green);
          check_field("blue", want.blue, rsp_if.blue);
          check_field("status", 8'(want.status), 8'(rsp_if.status));
        end
      end
    end
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold_cycles > 0) begin
        rsp_hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d reads pending", cycle_count, pending_pixels.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    mismatches      = 0;
    items_sent      = 0;
    idle_pct        = IDLE_PCT;
    rsp_hold_cycles = 0;
    depth_reg       = dpf_pkg::RST_BPP;
    width_reg       = dpf_pkg::RST_WIDTH;
    height_reg      = dpf_pkg::RST_HEIGHT;
    base_reg        = dpf_pkg::RST_BASE;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= dpf_pkg::CFG_BPP;
    cfg_data_i            <= '0;
    req_if.valid          <= 1'b0;
    req_if.operation      <= dpf_pkg::OP_READ;
    req_if.byte_address   <= '0;
    req_if.byte_value     <= '0;
    req_if.palette_index  <= '0;
    req_if.palette_color  <= '0;
    req_if.pixel_x        <= '0;
    req_if.pixel_y        <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_indexed_depths();
    test_direct_color();
    test_error_status();
    test_backpressure();
    test_random_traffic();
    settle();
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
